// ----- sv/phbp_pkg.sv -----
// Shared types and constants for the pipeline hazard unit with a one-bit
// branch history table. No dependencies.
package phbp_pkg;

  // History table geometry. TABLE_ENTRIES must be a power of two.
  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned INDEX_LOW_BIT = 4;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);

  // Field widths
  localparam int unsigned TYPE_W = 4;
  localparam int unsigned REG_W  = 8;
  localparam int unsigned ADDR_W = 32;

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_IDX_MODE = 1'b0;  // paddr[2] selects the register slot

  // Prediction modes
  localparam logic [1:0] MODE_TAKEN = 2'd0;
  localparam logic [1:0] MODE_BHT   = 2'd1;
  localparam logic [1:0] MODE_NONE  = 2'd2;

  typedef enum logic [TYPE_W-1:0] {
    INSTR_NOP     = 4'd0,
    INSTR_RTYPE   = 4'd1,
    INSTR_ITYPE   = 4'd2,
    INSTR_LOAD    = 4'd3,
    INSTR_STORE   = 4'd4,
    INSTR_BRANCH  = 4'd5,
    INSTR_JTYPE   = 4'd6,
    INSTR_JRTYPE  = 4'd7,
    INSTR_SPECIAL = 4'd8
  } instr_e;

  typedef enum logic [1:0] {
    HZ_NONE     = 2'd0,
    HZ_LOAD_USE = 2'd1,
    HZ_CONTROL  = 2'd2
  } hazard_e;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } bht_rd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic             taken;
  } bht_wr_t;

  typedef struct packed {
    logic valid;
    logic taken;
  } bht_entry_t;

endpackage

// ----- sv/phbp_bht.sv -----
// One-bit branch history table: taken bits in a synchronous memory, valid bits
// in flops. Depends on phbp_pkg.
module phbp_bht (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  phbp_pkg::bht_rd_t    rd_i,
  input  phbp_pkg::bht_wr_t    wr_i,
  output phbp_pkg::bht_entry_t entry_o
);
  import phbp_pkg::*;

  logic                     mem_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld_q;
  logic                     rd_taken_q;
  logic                     rd_vld_q;
  logic                     fwd_hit_q;
  logic                     fwd_taken_q;

  // taken-bit storage, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.taken;
    end
    if (rd_i.en) begin
      rd_taken_q  <= mem_q[rd_i.idx];
      fwd_taken_q <= wr_i.taken;
    end
  end

  // valid bits and read-side control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.idx] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_vld_q  <= vld_q[rd_i.idx];
        // same-cycle write to the entry being read: bypass the new value
        fwd_hit_q <= wr_i.en && (wr_i.idx == rd_i.idx);
      end
    end
  end

  assign entry_o.valid = fwd_hit_q | rd_vld_q;
  assign entry_o.taken = fwd_hit_q ? fwd_taken_q : rd_taken_q;

endmodule

// ----- sv/pipeline_hazard_and_branch_predictor.sv -----
// Pipeline hazard unit with a one-bit branch history table: top level.
// A result is registered in the output stage, or in the skid stage while the output is stalled.
// Throughput: one beat per cycle while the skid stage is empty; the table read for an
// instruction is issued when its predecessor is accepted, so the BHT port never holds input.
// Reset: mode 0, no predecessor, all table entries invalid at once (valid bits
// live in flops), output and skid stages empty. Depends on phbp_pkg, phbp_bht.
module pipeline_hazard_and_branch_predictor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // APB configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [phbp_pkg::PADDR_W-1:0]   paddr,
  input  logic [phbp_pkg::PDATA_W-1:0]   pwdata,
  output logic [phbp_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  // instruction channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [phbp_pkg::TYPE_W-1:0]    instr_type_i,
  input  logic [phbp_pkg::REG_W-1:0]     src_reg_a_i,
  input  logic [phbp_pkg::REG_W-1:0]     src_reg_b_i,
  input  logic [phbp_pkg::REG_W-1:0]     dest_reg_i,
  input  logic [phbp_pkg::ADDR_W-1:0]    pc_i,
  input  logic [phbp_pkg::ADDR_W-1:0]    target_addr_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           insert_bubble_o,
  output logic [1:0]                     hazard_kind_o,
  output logic                           prev_branch_taken_o
);
  import phbp_pkg::*;

  typedef struct packed {
    logic    bubble;
    hazard_e kind;
    logic    taken;
  } result_t;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [1:0] mode_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TAKEN;
    end else if (cfg_wr) begin
      mode_q <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_IDX_MODE) begin
      prdata = {{(PDATA_W-2){1'b0}}, mode_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: output register plus one skid stage. Input stalls only when the
  // skid stage holds a beat, so a waiting result never blocks acceptance.
  // ---------------------------------------------------------------------------
  logic    in_acc;
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q, res;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;

  // ---------------------------------------------------------------------------
  // Predecessor state
  // ---------------------------------------------------------------------------
  logic               prev_present_q;
  instr_e             prev_kind_q;
  logic [REG_W-1:0]   prev_dest_q;
  logic [ADDR_W-1:0]  prev_target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_present_q <= 1'b0;
      prev_kind_q    <= INSTR_NOP;
    end else if (in_acc) begin
      prev_present_q <= 1'b1;
      prev_kind_q    <= instr_e'(instr_type_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      prev_dest_q   <= dest_reg_i;
      prev_target_q <= target_addr_i;
    end
  end

  // ---------------------------------------------------------------------------
  // History table. The read for the next instruction is launched with this
  // beat using its own target, so the entry is ready when the successor comes.
  // The successor's update writes the same entry only after it has been used.
  // ---------------------------------------------------------------------------
  bht_rd_t    bht_rd;
  bht_wr_t    bht_wr;
  bht_entry_t bht_entry;

  logic prev_ctrl, taken, use_a, use_b, conflict, predicted;

  assign bht_rd.en  = in_acc;
  assign bht_rd.idx = target_addr_i[INDEX_LOW_BIT +: IDX_W];

  assign bht_wr.en    = in_acc && prev_present_q && prev_ctrl && (mode_q == MODE_BHT);
  assign bht_wr.idx   = prev_target_q[INDEX_LOW_BIT +: IDX_W];
  assign bht_wr.taken = taken;

  phbp_bht u_bht (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_i    (bht_rd),
    .wr_i    (bht_wr),
    .entry_o (bht_entry)
  );

  // ---------------------------------------------------------------------------
  // Hazard decision for the incoming beat
  // ---------------------------------------------------------------------------
  always_comb begin
    use_a = 1'b0;
    use_b = 1'b0;
    case (instr_e'(instr_type_i))
      INSTR_RTYPE, INSTR_STORE, INSTR_BRANCH: begin
        use_a = 1'b1;
        use_b = 1'b1;
      end
      INSTR_ITYPE, INSTR_LOAD, INSTR_JRTYPE: begin
        use_a = 1'b1;
      end
      default: begin
        use_a = 1'b0;
      end
    endcase
  end

  assign conflict  = (use_a && (src_reg_a_i == prev_dest_q)) ||
                     (use_b && (src_reg_b_i == prev_dest_q));
  assign prev_ctrl = (prev_kind_q == INSTR_BRANCH) || (prev_kind_q == INSTR_JTYPE) ||
                     (prev_kind_q == INSTR_JRTYPE);
  assign taken     = (pc_i == prev_target_q);
  // invalid entry predicts not-taken
  assign predicted = bht_entry.valid && bht_entry.taken;

  always_comb begin
    res = '{bubble: 1'b0, kind: HZ_NONE, taken: 1'b0};
    if (prev_present_q) begin
      if (prev_kind_q == INSTR_LOAD) begin
        if (conflict) begin
          res.bubble = 1'b1;
          res.kind   = HZ_LOAD_USE;
        end
      end else if (prev_ctrl) begin
        res.taken = taken;
        case (mode_q)
          MODE_TAKEN: begin
            if (taken) begin
              res.bubble = 1'b1;
              res.kind   = HZ_CONTROL;
            end
          end
          MODE_BHT: begin
            if (predicted != taken) begin
              res.bubble = 1'b1;
              res.kind   = HZ_CONTROL;
            end
          end
          default: begin
            // no control bubbles
            res.bubble = 1'b0;
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output and skid stages
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q  <= skid_valid_q || in_acc;
      skid_valid_q <= 1'b0;
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign insert_bubble_o     = out_q.bubble;
  assign hazard_kind_o       = out_q.kind;
  assign prev_branch_taken_o = out_q.taken;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full while output stage empty");

  a_bubble_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (insert_bubble_o == (hazard_kind_o != HZ_NONE)))
    else $error("bubble flag disagrees with hazard kind");

  a_load_use_not_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (hazard_kind_o == HZ_LOAD_USE)) |-> !prev_branch_taken_o)
    else $error("load-use hazard reported with a taken branch");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (out_valid_q && prev_present_q))
    else $error("accepted beat produced no result");

  a_bht_write_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bht_wr.en |-> (prev_present_q && (mode_q == MODE_BHT)))
    else $error("history table written outside predictor mode");

endmodule

// ----- tb/pipeline_hazard_and_branch_predictor_tb.sv -----
// Self-checking testbench for the pipeline hazard unit with a one-bit BHT.
// Drives instruction beats, predicts bubbles, hazard kinds and taken flags in-house and
// checks every result beat. Depends on phbp_pkg and the top level only.
module pipeline_hazard_and_branch_predictor_tb;
  import phbp_pkg::*;

  // Codes the package leaves unnamed: the spare mode and the unused types
  localparam logic [1:0]        MODE_SPARE    = 2'd3;
  localparam logic [TYPE_W-1:0] INSTR_SPARE_LO = 4'd9;
  localparam logic [TYPE_W-1:0] INSTR_SPARE_HI = 4'd15;

  // Register slots: paddr[2] picks the slot, the other slot is unmapped
  localparam logic [PADDR_W-1:0] ADDR_MODE  = {REG_IDX_MODE, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_EMPTY = {~REG_IDX_MODE, 2'b00};

  // Cycles with no beat on either channel before the run is abandoned
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    logic [TYPE_W-1:0] op;
    logic [REG_W-1:0]  src_a;
    logic [REG_W-1:0]  src_b;
    logic [REG_W-1:0]  dest;
    logic [ADDR_W-1:0] pc;
    logic [ADDR_W-1:0] target;
  } instr_beat_t;

  typedef struct packed {
    logic    bubble;
    hazard_e kind;
    logic    taken;
  } verdict_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [TYPE_W-1:0] instr_type_i  = '0;
  logic [REG_W-1:0]  src_reg_a_i   = '0;
  logic [REG_W-1:0]  src_reg_b_i   = '0;
  logic [REG_W-1:0]  dest_reg_i    = '0;
  logic [ADDR_W-1:0] pc_i          = '0;
  logic [ADDR_W-1:0] target_addr_i = '0;

  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       insert_bubble_o;
  logic [1:0] hazard_kind_o;
  logic       prev_branch_taken_o;

  pipeline_hazard_and_branch_predictor u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .instr_type_i       (instr_type_i),
    .src_reg_a_i        (src_reg_a_i),
    .src_reg_b_i        (src_reg_b_i),
    .dest_reg_i         (dest_reg_i),
    .pc_i               (pc_i),
    .target_addr_i      (target_addr_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .insert_bubble_o    (insert_bubble_o),
    .hazard_kind_o      (hazard_kind_o),
    .prev_branch_taken_o(prev_branch_taken_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Shadow copy of the hazard unit: mode, predecessor and history table
  // ---------------------------------------------------------------------
  logic [1:0]        mode_now = MODE_TAKEN;
  logic              have_prev = 1'b0;
  logic [TYPE_W-1:0] prev_op   = '0;
  logic [REG_W-1:0]  prev_dest = '0;
  logic [ADDR_W-1:0] prev_tgt  = '0;
  bht_entry_t        history [TABLE_ENTRIES];

  instr_beat_t fetch_q[$];          // beats waiting for the driver
  verdict_t    pending_verdicts[$]; // expected result beats, oldest first
  instr_beat_t last_queued = '0;    // feeds the sequence-aware generator

  int unsigned beats_queued = 0;
  int unsigned beats_taken  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors       = 0;
  logic        steady       = 1'b0; // no idling on either side while set
  logic        in_fire      = 1'b0; // input beat accepted at the last rising edge

  // One bubble decision per accepted beat; also advances the shadow state.
  function automatic verdict_t predict_hazard(instr_beat_t b);
    verdict_t         v;
    logic             reads_dest;
    logic             predicted;
    logic [IDX_W-1:0] slot;
    v = '{bubble: 1'b0, kind: HZ_NONE, taken: 1'b0};
    if (have_prev) begin
      if (prev_op == INSTR_LOAD) begin
        // load-use: which sources count depends on the consumer's type
        case (b.op)
          INSTR_RTYPE, INSTR_STORE, INSTR_BRANCH: begin
            reads_dest = (b.src_a == prev_dest) || (b.src_b == prev_dest);
          end
          INSTR_ITYPE, INSTR_LOAD, INSTR_JRTYPE: begin
            reads_dest = (b.src_a == prev_dest);
          end
          default: begin
            reads_dest = 1'b0;
          end
        endcase
        if (reads_dest) begin
          v.bubble = 1'b1;
          v.kind   = HZ_LOAD_USE;
        end
      end else if (prev_op inside {INSTR_BRANCH, INSTR_JTYPE, INSTR_JRTYPE}) begin
        // taken means the fetch went to the predecessor's target
        v.taken = (b.pc == prev_tgt);
        if (mode_now == MODE_TAKEN) begin
          if (v.taken) begin
            v.bubble = 1'b1;
            v.kind   = HZ_CONTROL;
          end
        end else if (mode_now == MODE_BHT) begin
          slot      = prev_tgt[INDEX_LOW_BIT +: IDX_W];
          predicted = history[slot].valid & history[slot].taken;
          if (predicted != v.taken) begin
            v.bubble = 1'b1;
            v.kind   = HZ_CONTROL;
          end
          history[slot] = '{valid: 1'b1, taken: v.taken};
        end
        // MODE_NONE and the spare mode never stall on control
      end
    end
    have_prev = 1'b1;
    prev_op   = b.op;
    prev_dest = b.dest;
    prev_tgt  = b.target;
    return v;
  endfunction

  function automatic logic take_break();
    return !steady && ($urandom_range(0, 99) < 22);
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: new beat only once the current one is gone, payload held
  // while stalled. Result-side stall is random on every cycle unless steady is set.
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin : drive
    instr_beat_t nb;
    if (!in_valid_i || in_fire) begin
      if (rst_ni && fetch_q.size() != 0 && !take_break()) begin
        nb            = fetch_q.pop_front();
        instr_type_i  <= nb.op;
        src_reg_a_i   <= nb.src_a;
        src_reg_b_i   <= nb.src_b;
        dest_reg_i    <= nb.dest;
        pc_i          <= nb.pc;
        target_addr_i <= nb.target;
        in_valid_i    <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= take_break();
  end

  // ---------------------------------------------------------------------
  // Monitor: check result beats in order, predict for each input beat,
  // and watch for a hung handshake.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    verdict_t    want;
    instr_beat_t seen;
    logic        out_fire;
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    if (out_fire) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result beat with nothing expected (bubble %0d kind %0d taken %0d)",
                 $time, insert_bubble_o, hazard_kind_o, prev_branch_taken_o);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("insert_bubble", want.bubble, insert_bubble_o);
        check_field("hazard_kind", want.kind, hazard_kind_o);
        check_field("prev_branch_taken", want.taken, prev_branch_taken_o);
      end
    end
    if (in_fire) begin
      seen = '{op: instr_type_i, src_a: src_reg_a_i, src_b: src_reg_b_i,
               dest: dest_reg_i, pc: pc_i, target: target_addr_i};
      pending_verdicts.push_back(predict_hazard(seen));
      beats_taken++;
    end
    if (!rst_ni || in_fire || out_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Configuration and stimulus
  // ---------------------------------------------------------------------
  task automatic apb_xfer(input logic wr, input logic [PADDR_W-1:0] addr,
                          input logic [PDATA_W-1:0] wdata,
                          output logic [PDATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a slot, then read the mode back; the unmapped slot must not touch it.
  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [1:0] value);
    logic [PDATA_W-1:0] rd;
    apb_xfer(1'b1, addr, {{(PDATA_W-2){1'b0}}, value}, rd);
    if (addr == ADDR_MODE) mode_now = value;
    apb_xfer(1'b0, ADDR_MODE, '0, rd);
    if (rd[1:0] !== mode_now) begin
      $display("%0t: prediction_mode readback expected %0d got %0d", $time, mode_now, rd[1:0]);
      errors++;
    end
  endtask

  task automatic push_beat(input logic [TYPE_W-1:0] op, input logic [REG_W-1:0] a,
                           input logic [REG_W-1:0] b, input logic [REG_W-1:0] d,
                           input logic [ADDR_W-1:0] pc, input logic [ADDR_W-1:0] tgt);
    last_queued = '{op: op, src_a: a, src_b: b, dest: d, pc: pc, target: tgt};
    fetch_q.push_back(last_queued);
    beats_queued++;
  endtask

  // Mostly narrow register numbers so they collide, targets from a small pool
  // so history slots get revisited, and the next pc often lands on the target.
  task automatic queue_random_beats(input int unsigned count);
    logic [TYPE_W-1:0]  op;
    logic [REG_W-1:0]   ra, rb, rd;
    logic [ADDR_W-1:0]  pc, tgt;
    int unsigned        pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) op = INSTR_LOAD;
      else if (pick < 50) op = TYPE_W'($urandom_range(INSTR_BRANCH, INSTR_JRTYPE));
      else if (pick < 92) op = TYPE_W'($urandom_range(INSTR_NOP, INSTR_SPECIAL));
      else op = TYPE_W'($urandom_range(INSTR_SPARE_LO, INSTR_SPARE_HI));
      ra = REG_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, 255));
      rb = REG_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, 255));
      rd = REG_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, 255));
      if (last_queued.op == INSTR_LOAD && $urandom_range(0, 9) < 6) begin
        if ($urandom_range(0, 1)) ra = last_queued.dest;
        else rb = last_queued.dest;
      end
      if ($urandom_range(0, 3) == 0) begin
        tgt = $urandom;
      end else begin
        tgt = ($urandom_range(0, 3) << 16) | ($urandom_range(0, 7) << INDEX_LOW_BIT)
              | ($urandom_range(0, 3) << 2);
      end
      pick = $urandom_range(0, 99);
      if (last_queued.op inside {INSTR_BRANCH, INSTR_JTYPE, INSTR_JRTYPE} && pick < 55)
        pc = last_queued.target;
      else if (pick < 70) pc = last_queued.target ^ 32'h4; // near miss
      else pc = $urandom;
      push_beat(op, ra, rb, rd, pc, tgt);
    end
  endtask

  // Idle point: every queued beat accepted and every result checked.
  task automatic wait_drained();
    while (beats_taken != beats_queued || pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) history[i] = '{valid: 1'b0, taken: 1'b0};
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, reset mode (stall whenever taken)
    push_beat(INSTR_RTYPE, 8'd0, 8'd0, 8'd0, 32'h0, 32'h0);        // first beat: registers and addresses zero
    push_beat(INSTR_LOAD, 8'd1, 8'd2, 8'd0, 32'h4, 32'h0);
    push_beat(INSTR_RTYPE, 8'd9, 8'd0, 8'd3, 32'h8, 32'h0);        // register zero, via b
    push_beat(INSTR_LOAD, 8'd4, 8'd4, 8'd255, 32'hC, 32'h0);
    push_beat(INSTR_ITYPE, 8'd1, 8'd255, 8'd5, 32'h10, 32'h0);     // b ignored for itype
    push_beat(INSTR_LOAD, 8'd4, 8'd4, 8'd255, 32'h14, 32'h0);
    push_beat(INSTR_STORE, 8'd1, 8'd255, 8'd6, 32'h18, 32'h0);     // store reads b
    push_beat(INSTR_LOAD, 8'd4, 8'd4, 8'd17, 32'h1C, 32'h0);
    push_beat(INSTR_BRANCH, 8'd17, 8'd3, 8'd0, 32'h20, 32'h100);   // load-use on a
    push_beat(INSTR_JTYPE, 8'd0, 8'd0, 8'd0, 32'h100, 32'hFFFF_FFFF); // branch taken
    push_beat(INSTR_JRTYPE, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF, 32'h40); // jump taken
    push_beat(INSTR_NOP, 8'd255, 8'd255, 8'd255, 32'h44, 32'h0);   // jr not taken
    push_beat(INSTR_LOAD, 8'd0, 8'd0, 8'd7, 32'h48, 32'h0);
    push_beat(INSTR_JRTYPE, 8'd7, 8'd1, 8'd0, 32'h4C, 32'h200);    // jr reads a
    push_beat(INSTR_LOAD, 8'd0, 8'd0, 8'd7, 32'h200, 32'h0);       // jr taken
    push_beat(INSTR_JTYPE, 8'd7, 8'd7, 8'd0, 32'h208, 32'h0);      // jtype reads nothing
    push_beat(INSTR_LOAD, 8'd0, 8'd0, 8'd8, 32'h20C, 32'h0);
    push_beat(INSTR_SPECIAL, 8'd8, 8'd8, 8'd0, 32'h210, 32'h0);
    push_beat(INSTR_LOAD, 8'd0, 8'd0, 8'd9, 32'h214, 32'h0);
    push_beat(INSTR_SPARE_HI, 8'd9, 8'd9, 8'd0, 32'h218, 32'h0);   // unused type
    push_beat(INSTR_LOAD, 8'd0, 8'd0, 8'd9, 32'h21C, 32'h0);
    push_beat(INSTR_SPARE_LO, 8'd9, 8'd9, 8'd0, 32'h220, 32'h0);
    push_beat(INSTR_LOAD, 8'd0, 8'd0, 8'd200, 32'h224, 32'h0);
    push_beat(INSTR_LOAD, 8'd200, 8'd0, 8'd1, 32'h228, 32'h0);     // load after load
    push_beat(INSTR_ITYPE, 8'd1, 8'd0, 8'd0, 32'h22C, 32'h0);
    wait_drained();

    // Unmapped slot must be ignored, then the history table predictor
    write_reg(ADDR_EMPTY, MODE_NONE);
    write_reg(ADDR_MODE, MODE_BHT);
    queue_random_beats(160);
    wait_drained();

    write_reg(ADDR_MODE, MODE_NONE);
    queue_random_beats(130);
    wait_drained();

    // Back-to-back beats on both sides for a whole phase
    write_reg(ADDR_MODE, MODE_TAKEN);
    steady = 1'b1;
    queue_random_beats(160);
    wait_drained();
    steady = 1'b0;

    write_reg(ADDR_MODE, MODE_SPARE);
    queue_random_beats(110);
    wait_drained();

    // Table contents must have survived the other modes
    write_reg(ADDR_MODE, MODE_BHT);
    queue_random_beats(220);
    wait_drained();

    repeat (4) @(negedge clk_i);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/phbp_pkg.sv
sv/phbp_bht.sv
sv/pipeline_hazard_and_branch_predictor.sv
tb/pipeline_hazard_and_branch_predictor_tb.sv
